@@ design/assert_macros.svh @@
// assertion macros used by the stepper core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/eps_pkg.sv @@
// types, constants and microcode program of the ellipse point stepper
package eps_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;

  // operation codes of a command transaction
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // walk direction register values
  localparam logic DIR_X_FIRST = 1'b0;
  localparam logic DIR_Y_FIRST = 1'b1;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // microcode addresses
  localparam upc_t UA_S0 = 5'd0;
  localparam upc_t UA_S1 = 5'd1;
  localparam upc_t UA_S2 = 5'd2;
  localparam upc_t UA_S3 = 5'd3;
  localparam upc_t UA_S4 = 5'd4;
  localparam upc_t UA_S5 = 5'd5;
  localparam upc_t UA_A0 = 5'd6;
  localparam upc_t UA_A1 = 5'd7;
  localparam upc_t UA_A2 = 5'd8;
  localparam upc_t UA_A3 = 5'd9;
  localparam upc_t UA_A4 = 5'd10;
  localparam upc_t UA_A5 = 5'd11;
  localparam upc_t UA_A6 = 5'd12;
  localparam upc_t UA_A7 = 5'd13;
  localparam upc_t UA_E0 = 5'd14;
  localparam upc_t UA_E1 = 5'd15;
  localparam upc_t UA_E2 = 5'd16;
  localparam upc_t UA_E3 = 5'd17;
  localparam upc_t UA_E4 = 5'd18;
  localparam upc_t UA_E5 = 5'd19;
  localparam upc_t UA_E6 = 5'd20;
  localparam upc_t UA_R0 = 5'd21;
  localparam upc_t UA_R1 = 5'd22;
  localparam upc_t UA_R2 = 5'd23;
  localparam upc_t UA_R3 = 5'd24;
  localparam upc_t UA_Z  = 5'd25;
  localparam upc_t UA_ZN = 5'd26;

  // multiplier operand a
  typedef enum logic [1:0] {MA_F, MA_S, MA_2F1, MA_SM1} ma_sel_t;

  // multiplier operand b (f = fast offset, s = slow offset)
  typedef enum logic [3:0] {
    MB_ONE, MB_F, MB_S, MB_Q, MB_2F1, MB_SM1, MB_4F4, MB_4SM2,
    MB_4SM1, MB_2F3, MB_2S2, MB_3M2S, MB_2F2
  } mb_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD_P, ACC_ADD_P, ACC_SUB_P, ACC_LOAD_D
  } acc_op_t;

  typedef enum logic [2:0] {
    BR_NEXT, BR_JUMP, BR_ACC_NN, BR_D_NN, BR_D_NEG, BR_R2
  } branch_t;

  typedef enum logic [1:0] {EM_NONE, EM_POINT, EM_NULL} emit_t;

  // one control word
  typedef struct packed {
    ma_sel_t ma;
    mb_sel_t mb;
    acc_op_t acc;
    logic    shl2;
    logic    ld_d;
    logic    ld_q;
    logic    ld_f;
    logic    ld_s;
    logic    f_inc;
    logic    s_dec;
    logic    set_r2;
    branch_t br;
    emit_t   em;
    upc_t    target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic acc_nn;
    logic d_neg;
    logic region2;
    logic s_zero;
  } status_t;

  localparam ctrl_t UC_NOP = '{
    ma: MA_F, mb: MB_ONE, acc: ACC_HOLD, shl2: 1'b0, ld_d: 1'b0, ld_q: 1'b0,
    ld_f: 1'b0, ld_s: 1'b0, f_inc: 1'b0, s_dec: 1'b0, set_r2: 1'b0,
    br: BR_NEXT, em: EM_NONE, target: UA_S0
  };

  // program: F, S are the squared coefficients of the fast and slow axis,
  // P the product register (registered multiplier output), D the decision variable
  function automatic ctrl_t ucode(input upc_t upc);
    ctrl_t c;
    c = UC_NOP;
    unique case (upc)
      // start: square radii, d = 4F - S(4s-1)
      UA_S0: begin c.ma = MA_F; c.mb = MB_F; end
      UA_S1: begin c.ma = MA_S; c.mb = MB_S; c.ld_f = 1'b1; end
      UA_S2: begin c.ma = MA_F; c.mb = MB_ONE; c.ld_s = 1'b1; end
      UA_S3: begin c.ma = MA_S; c.mb = MB_4SM1; c.acc = ACC_LOAD_P; c.shl2 = 1'b1; end
      UA_S4: begin c.acc = ACC_SUB_P; end
      UA_S5: begin c.ld_d = 1'b1; c.br = BR_JUMP; c.target = UA_Z; end
      // advance: region test 4F(f+1) - S(4s-2)
      UA_A0: begin
        c.ma = MA_F; c.mb = MB_4F4; c.br = BR_R2; c.target = UA_R0;
      end
      UA_A1: begin c.ma = MA_S; c.mb = MB_4SM2; c.acc = ACC_LOAD_P; end
      UA_A2: begin c.ma = MA_F; c.mb = MB_2F3; c.acc = ACC_SUB_P; end
      UA_A3: begin
        c.ma = MA_F; c.mb = MB_2F3; c.acc = ACC_LOAD_D;
        c.br = BR_ACC_NN; c.target = UA_E0;
      end
      // region one update
      UA_A4: begin c.ma = MA_S; c.mb = MB_2S2; c.acc = ACC_ADD_P; c.shl2 = 1'b1; end
      UA_A5: begin
        c.ma = MA_S; c.mb = MB_2S2; c.br = BR_D_NEG; c.target = UA_A7;
      end
      UA_A6: begin c.acc = ACC_SUB_P; c.shl2 = 1'b1; c.s_dec = 1'b1; end
      UA_A7: begin
        c.ld_d = 1'b1; c.f_inc = 1'b1; c.br = BR_JUMP; c.target = UA_Z;
      end
      // region two entry: d = F(2f+1)^2 + 4S(s-1)^2 - 4FS
      UA_E0: begin c.ma = MA_2F1; c.mb = MB_2F1; end
      UA_E1: begin c.ma = MA_SM1; c.mb = MB_SM1; c.ld_q = 1'b1; end
      UA_E2: begin c.ma = MA_F; c.mb = MB_Q; c.ld_q = 1'b1; end
      UA_E3: begin c.ma = MA_S; c.mb = MB_Q; c.acc = ACC_LOAD_P; end
      UA_E4: begin c.ma = MA_F; c.mb = MB_S; c.acc = ACC_ADD_P; c.shl2 = 1'b1; end
      UA_E5: begin c.acc = ACC_SUB_P; c.shl2 = 1'b1; end
      UA_E6: begin c.ld_d = 1'b1; c.set_r2 = 1'b1; end
      // region two update
      UA_R0: begin c.ma = MA_S; c.mb = MB_3M2S; c.acc = ACC_LOAD_D; end
      UA_R1: begin
        c.ma = MA_F; c.mb = MB_2F2; c.acc = ACC_ADD_P; c.shl2 = 1'b1;
        c.br = BR_D_NN; c.target = UA_R3;
      end
      UA_R2: begin c.acc = ACC_ADD_P; c.shl2 = 1'b1; c.f_inc = 1'b1; end
      UA_R3: begin c.ld_d = 1'b1; c.s_dec = 1'b1; end
      // result
      UA_Z:  begin c.em = EM_POINT; end
      UA_ZN: begin c.em = EM_NULL; end
      default: c = UC_NOP;
    endcase
    return c;
  endfunction

endpackage

@@ design/eps_if.sv @@
// command and point channel interfaces of the ellipse point stepper
interface eps_cmd_if #(
  parameter int RADIUS_BITS = eps_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = eps_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius_a;
  logic        [RADIUS_BITS-1:0] radius_b;

  modport source (
    output valid, operation, center_x, center_y, radius_a, radius_b,
    input  ready
  );
  modport sink (
    input  valid, operation, center_x, center_y, radius_a, radius_b,
    output ready
  );
endinterface

interface eps_pt_if #(
  parameter int COORD_BITS = eps_pkg::COORD_BITS_DEF
);
  localparam int OW = COORD_BITS + 1;

  logic                 valid;
  logic                 ready;
  logic                 point_valid;
  logic signed [OW-1:0] right_x;
  logic signed [OW-1:0] left_x;
  logic signed [OW-1:0] upper_y;
  logic signed [OW-1:0] lower_y;
  logic                 done_res;

  modport source (
    output valid, point_valid, right_x, left_x, upper_y, lower_y, done_res,
    input  ready
  );
  modport sink (
    input  valid, point_valid, right_x, left_x, upper_y, lower_y, done_res,
    output ready
  );
endinterface

@@ design/eps_datapath.sv @@
// arithmetic datapath: shared multiplier, accumulator, decision and walk offsets
module eps_datapath #(
  parameter int RADIUS_BITS = eps_pkg::RADIUS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  eps_pkg::ctrl_t         ctl,
  input  logic                   start_load,
  input  logic [RADIUS_BITS-1:0] start_rf,
  input  logic [RADIUS_BITS-1:0] start_rs,
  output eps_pkg::status_t       stat,
  output logic [RADIUS_BITS:0]   fast_pos,
  output logic [RADIUS_BITS-1:0] slow_pos
);

  localparam int SQ_W = 2 * RADIUS_BITS;
  localparam int WA   = SQ_W + 1;
  localparam int WB   = SQ_W + 5;
  localparam int QW   = SQ_W + 4;
  localparam int PW   = WA + WB;
  localparam int DW   = PW + 2;

  localparam logic signed [WB-1:0] K1 = 1;
  localparam logic signed [WB-1:0] K2 = 2;
  localparam logic signed [WB-1:0] K3 = 3;
  localparam logic signed [WB-1:0] K4 = 4;

  logic        [SQ_W-1:0] coef_f;
  logic        [SQ_W-1:0] coef_s;
  logic        [QW-1:0]   sq;
  logic signed [PW-1:0]   prod;
  logic signed [DW-1:0]   acc;
  logic signed [DW-1:0]   dec;
  logic                   region2;

  logic signed [WB-1:0] fx, sx;
  logic signed [WB-1:0] t_2f1, t_sm1, t_4f4, t_4sm2, t_4sm1, t_2f3, t_2s2, t_3m2s, t_2f2;
  logic signed [WA-1:0] op_a;
  logic signed [WB-1:0] op_b;
  logic signed [PW-1:0] mul_res;
  logic signed [DW-1:0] p_ext;

  // offset terms
  assign fx     = $signed({{(WB-RADIUS_BITS-1){1'b0}}, fast_pos});
  assign sx     = $signed({{(WB-RADIUS_BITS){1'b0}}, slow_pos});
  assign t_2f1  = fx + fx + K1;
  assign t_sm1  = sx - K1;
  assign t_4f4  = (fx <<< 2) + K4;
  assign t_4sm2 = (sx <<< 2) - K2;
  assign t_4sm1 = (sx <<< 2) - K1;
  assign t_2f3  = fx + fx + K3;
  assign t_2s2  = sx + sx - K2;
  assign t_3m2s = K3 - sx - sx;
  assign t_2f2  = fx + fx + K2;

  // operand a select
  always_comb begin
    unique case (ctl.ma)
      eps_pkg::MA_F:   op_a = $signed({1'b0, coef_f});
      eps_pkg::MA_S:   op_a = $signed({1'b0, coef_s});
      eps_pkg::MA_2F1: op_a = $signed(t_2f1[WA-1:0]);
      eps_pkg::MA_SM1: op_a = $signed(t_sm1[WA-1:0]);
      default:         op_a = '0;
    endcase
  end

  // operand b select
  always_comb begin
    unique case (ctl.mb)
      eps_pkg::MB_ONE:  op_b = K1;
      eps_pkg::MB_F:    op_b = $signed({{(WB-SQ_W){1'b0}}, coef_f});
      eps_pkg::MB_S:    op_b = $signed({{(WB-SQ_W){1'b0}}, coef_s});
      eps_pkg::MB_Q:    op_b = $signed({1'b0, sq});
      eps_pkg::MB_2F1:  op_b = t_2f1;
      eps_pkg::MB_SM1:  op_b = t_sm1;
      eps_pkg::MB_4F4:  op_b = t_4f4;
      eps_pkg::MB_4SM2: op_b = t_4sm2;
      eps_pkg::MB_4SM1: op_b = t_4sm1;
      eps_pkg::MB_2F3:  op_b = t_2f3;
      eps_pkg::MB_2S2:  op_b = t_2s2;
      eps_pkg::MB_3M2S: op_b = t_3m2s;
      eps_pkg::MB_2F2:  op_b = t_2f2;
      default:          op_b = '0;
    endcase
  end

  assign mul_res = PW'(op_a) * PW'(op_b);
  assign p_ext   = ctl.shl2 ? $signed({prod, 2'b00}) : $signed({{2{prod[PW-1]}}, prod});

  // product register
  always_ff @(posedge clk) begin
    prod <= mul_res;
  end

  // accumulator, decision and square holder
  always_ff @(posedge clk) begin
    case (ctl.acc)
      eps_pkg::ACC_LOAD_P: acc <= p_ext;
      eps_pkg::ACC_ADD_P:  acc <= acc + p_ext;
      eps_pkg::ACC_SUB_P:  acc <= acc - p_ext;
      eps_pkg::ACC_LOAD_D: acc <= dec;
      default:             acc <= acc;
    endcase
    if (ctl.ld_d) begin
      dec <= acc;
    end
    if (ctl.ld_q) begin
      sq <= prod[QW-1:0];
    end
  end

  // coefficients and offsets
  always_ff @(posedge clk) begin
    if (start_load) begin
      coef_f   <= {{RADIUS_BITS{1'b0}}, start_rf};
      coef_s   <= {{RADIUS_BITS{1'b0}}, start_rs};
      fast_pos <= '0;
      slow_pos <= start_rf;
    end else begin
      if (ctl.ld_f) begin
        coef_f <= prod[SQ_W-1:0];
      end
      if (ctl.ld_s) begin
        coef_s <= prod[SQ_W-1:0];
      end
      if (ctl.f_inc) begin
        fast_pos <= fast_pos + 1'b1;
      end
      if (ctl.s_dec) begin
        slow_pos <= slow_pos - 1'b1;
      end
    end
  end

  // region flag
  always_ff @(posedge clk) begin
    if (rst) begin
      region2 <= 1'b0;
    end else if (start_load) begin
      region2 <= 1'b0;
    end else if (ctl.set_r2) begin
      region2 <= 1'b1;
    end
  end

  assign stat.acc_nn  = !acc[DW-1];
  assign stat.d_neg   = dec[DW-1];
  assign stat.region2 = region2;
  assign stat.s_zero  = (slow_pos == '0);

endmodule

@@ design/ellipse_point_stepper_core.sv @@
// top level of the midpoint ellipse point stepper with its microcode sequencer
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    operation, center_x, center_y, radius_a, radius_b
//   pt       out  valid/ready    point_valid, right_x, left_x, upper_y, lower_y, done_res
//   cfg      in   cfg_we         cfg_wdata (walk_direction)
//
// after acceptance a start runs the start steps, an advance the region test and region one or two update
// (entering region two, the entry steps first), an advance with no walk running only the
// null result; every step is one control word driving the one shared multiplier and accumulator
// cmd ready is low while the sequencer runs; a result waits in the output register
// and only the result step stalls on it, so a new command can enter meanwhile
// rst is synchronous and clears the sequencer, the walk and the output valid
`include "assert_macros.svh"

module ellipse_point_stepper_core #(
  parameter int RADIUS_BITS = eps_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = eps_pkg::COORD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  eps_cmd_if.sink cmd,
  eps_pt_if.source pt,
  input  logic    cfg_we,
  input  logic    cfg_wdata
);

  localparam int OW = COORD_BITS + 1;

  logic                          running;
  eps_pkg::upc_t                 upc;
  logic                          walk_dir;
  logic                          dir_l;
  logic                          walk_active;
  logic signed [COORD_BITS-1:0]  centre_x;
  logic signed [COORD_BITS-1:0]  centre_y;

  eps_pkg::ctrl_t                ctl;
  eps_pkg::status_t              stat;
  logic [RADIUS_BITS:0]          fast_pos;
  logic [RADIUS_BITS-1:0]        slow_pos;

  logic                          cmd_acc;
  logic                          start_load;
  logic [RADIUS_BITS-1:0]        start_rf;
  logic [RADIUS_BITS-1:0]        start_rs;
  logic                          slot_free;
  logic                          taken;
  logic                          emit_go;

  logic [OW-1:0]                 x_off, y_off;
  logic [OW-1:0]                 cx_ext, cy_ext;

  logic                          out_valid;
  logic                          out_point;
  logic signed [OW-1:0]          out_rx, out_lx, out_uy, out_ly;
  logic                          out_done;

  // command handshake
  assign cmd.ready  = !running;
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign start_load = cmd_acc && (cmd.operation == eps_pkg::OP_START);
  assign start_rf   = (walk_dir == eps_pkg::DIR_X_FIRST) ? cmd.radius_b : cmd.radius_a;
  assign start_rs   = (walk_dir == eps_pkg::DIR_X_FIRST) ? cmd.radius_a : cmd.radius_b;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_dir <= eps_pkg::DIR_Y_FIRST;
    end else if (cfg_we) begin
      walk_dir <= cfg_wdata;
    end
  end

  // control word fetch
  assign ctl       = running ? eps_pkg::ucode(upc) : eps_pkg::UC_NOP;
  assign slot_free = !out_valid || pt.ready;
  assign emit_go   = running && (ctl.em != eps_pkg::EM_NONE) && slot_free;

  // branch condition
  always_comb begin
    unique case (ctl.br)
      eps_pkg::BR_NEXT:   taken = 1'b0;
      eps_pkg::BR_JUMP:   taken = 1'b1;
      eps_pkg::BR_ACC_NN: taken = stat.acc_nn;
      eps_pkg::BR_D_NN:   taken = !stat.d_neg;
      eps_pkg::BR_D_NEG:  taken = stat.d_neg;
      eps_pkg::BR_R2:     taken = stat.region2;
      default:            taken = 1'b0;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      upc     <= eps_pkg::UA_S0;
    end else if (cmd_acc) begin
      running <= 1'b1;
      if (cmd.operation == eps_pkg::OP_START) begin
        upc <= eps_pkg::UA_S0;
      end else if (walk_active) begin
        upc <= eps_pkg::UA_A0;
      end else begin
        upc <= eps_pkg::UA_ZN;
      end
    end else if (running) begin
      if (ctl.em != eps_pkg::EM_NONE) begin
        if (slot_free) begin
          running <= 1'b0;
        end
      end else begin
        upc <= taken ? ctl.target : upc + eps_pkg::upc_t'(1);
      end
    end
  end

  // walk direction latched at start, walk activity updated at each emitted point
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_l       <= eps_pkg::DIR_X_FIRST;
      walk_active <= 1'b0;
    end else begin
      if (start_load) begin
        dir_l <= walk_dir;
      end
      if (emit_go && ctl.em == eps_pkg::EM_POINT) begin
        walk_active <= !stat.s_zero;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_load) begin
      centre_x <= cmd.center_x;
      centre_y <= cmd.center_y;
    end
  end

  eps_datapath #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .start_load(start_load),
    .start_rf  (start_rf),
    .start_rs  (start_rs),
    .stat      (stat),
    .fast_pos  (fast_pos),
    .slow_pos  (slow_pos)
  );

  // mirrored coordinates
  assign x_off  = (dir_l == eps_pkg::DIR_X_FIRST) ? OW'(fast_pos) : OW'(slow_pos);
  assign y_off  = (dir_l == eps_pkg::DIR_X_FIRST) ? OW'(slow_pos) : OW'(fast_pos);
  assign cx_ext = OW'(centre_x);
  assign cy_ext = OW'(centre_y);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (pt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (ctl.em == eps_pkg::EM_POINT) begin
        out_point <= 1'b1;
        out_rx    <= $signed(cx_ext + x_off);
        out_lx    <= $signed(cx_ext - x_off);
        out_uy    <= $signed(cy_ext + y_off);
        out_ly    <= $signed(cy_ext - y_off);
        out_done  <= stat.s_zero;
      end else begin
        out_point <= 1'b0;
        out_rx    <= '0;
        out_lx    <= '0;
        out_uy    <= '0;
        out_ly    <= '0;
        out_done  <= 1'b0;
      end
    end
  end

  assign pt.valid       = out_valid;
  assign pt.point_valid = out_point;
  assign pt.right_x     = out_rx;
  assign pt.left_x      = out_lx;
  assign pt.upper_y     = out_uy;
  assign pt.lower_y     = out_ly;
  assign pt.done_res    = out_done;

  // checks
  `ASSERT_NEXT(a_accept_runs, clk, rst, cmd.valid && cmd.ready, running, "accepted transaction did not start the sequencer")
  `ASSERT_IMPLY(a_done_ends_walk, clk, rst, pt.valid && pt.point_valid && pt.done_res, !walk_active, "walk still active behind a final point")
  `ASSERT_IMPLY(a_result_from_seq, clk, rst, $rose(pt.valid), $past(running), "result appeared without a running sequence")

endmodule
